/* rtl/core/wsf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsf_pkg
// Shared types, register indexes and the divisor reciprocal table for the
// 3x3 weighted smoothing filter.
// ----------------------------------------------------------------------------
package wsf_pkg;

    localparam int PIX_W       = 8;
    localparam int DIM_W       = 12;   // image_width / image_height registers
    localparam int WGT_W       = 3;    // center_weight register
    localparam int SUM_W       = 13;   // 255 * (7 + 12) fits in 13 bits
    localparam int RECIP_W     = 15;
    localparam int RECIP_SHIFT = 18;   // SUM_W + 5, exact for divisors below 32
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_WEIGHT = 2'd2;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd480;
    localparam logic [WGT_W-1:0] WEIGHT_RESET = 3'd4;
    localparam logic [DIM_W-1:0] MIN_DIM      = 12'd3;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SUM,
        ST_SCALE
    } wsf_state_t;

    // new window column: [0] upper row, [1] middle row, [2] current row
    typedef logic [2:0][PIX_W-1:0] wsf_col_t;

    typedef struct packed {
        logic emit;
        logic border;
        logic line_end;
        logic frame_end;
    } wsf_flags_t;

    // ceil(2^18 / (w + 12))
    function automatic logic [RECIP_W-1:0] wsf_recip(input logic [WGT_W-1:0] w);
        logic [RECIP_W-1:0] r;
        case (w)
            3'd0:    r = 15'd21846;
            3'd1:    r = 15'd20165;
            3'd2:    r = 15'd18725;
            3'd3:    r = 15'd17477;
            3'd4:    r = 15'd16384;
            3'd5:    r = 15'd15421;
            3'd6:    r = 15'd14564;
            default: r = 15'd13798;
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/wsf_line_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsf_line_store
// Upper and middle line memories, one read and one write port each, with a
// registered read.
// ----------------------------------------------------------------------------
module wsf_line_store #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                          clk,
    input  logic                          rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
    output logic [wsf_pkg::PIX_W-1:0]     upper_q,
    output logic [wsf_pkg::PIX_W-1:0]     middle_q,
    input  logic                          wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
    input  logic [wsf_pkg::PIX_W-1:0]     wr_upper,
    input  logic [wsf_pkg::PIX_W-1:0]     wr_middle
);
    import wsf_pkg::*;

    logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
    logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
    logic [PIX_W-1:0] upper_q_reg;
    logic [PIX_W-1:0] middle_q_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            upper_q_reg  <= upper_mem[rd_addr];
            middle_q_reg <= middle_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            upper_mem[wr_addr]  <= wr_upper;
            middle_mem[wr_addr] <= wr_middle;
        end
    end

    assign upper_q  = upper_q_reg;
    assign middle_q = middle_q_reg;

endmodule

/* rtl/core/wsf_window.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsf_window
// 3x3 neighborhood registers and the registered weighted kernel sum.
// ----------------------------------------------------------------------------
module wsf_window (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        shift_en,
    input  wsf_pkg::wsf_col_t           col_new,
    input  logic                        sum_en,
    input  logic [wsf_pkg::WGT_W-1:0]   weight,
    output logic [wsf_pkg::SUM_W-1:0]   sum,
    output logic [wsf_pkg::PIX_W-1:0]   center
);
    import wsf_pkg::*;

    // win_reg[row][col], col 2 is the newest
    logic [2:0][2:0][PIX_W-1:0] win_reg;
    logic [SUM_W-1:0]           sum_reg;
    logic [PIX_W-1:0]           center_reg;
    logic [SUM_W-1:0]           sum_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (shift_en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
                win_reg[i][2] <= col_new[i];
            end
        end
    end

    always_comb
    begin
        sum_next = SUM_W'(win_reg[0][0]) + SUM_W'(win_reg[0][2])
                 + SUM_W'(win_reg[2][0]) + SUM_W'(win_reg[2][2])
                 + ((SUM_W'(win_reg[0][1]) + SUM_W'(win_reg[1][0])
                   + SUM_W'(win_reg[1][2]) + SUM_W'(win_reg[2][1])) << 1)
                 + SUM_W'(weight) * SUM_W'(win_reg[1][1]);
    end

    always_ff @(posedge clk)
    begin
        if (sum_en)
        begin
            sum_reg    <= sum_next;
            center_reg <= win_reg[1][1];
        end
    end

    assign sum    = sum_reg;
    assign center = center_reg;

endmodule

/* rtl/core/wsf_scale.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsf_scale
// Divides the kernel sum by (weight + 12) through an exact reciprocal
// multiply, saturated to 8 bits.
// ----------------------------------------------------------------------------
module wsf_scale (
    input  logic [wsf_pkg::SUM_W-1:0]  sum,
    input  logic [wsf_pkg::WGT_W-1:0]  weight,
    output logic [wsf_pkg::PIX_W-1:0]  quotient
);
    import wsf_pkg::*;

    localparam int PROD_W = SUM_W + RECIP_W;
    localparam int QW     = PROD_W - RECIP_SHIFT;

    logic [PROD_W-1:0] prod;
    logic [QW-1:0]     q_wide;

    always_comb
    begin
        prod     = PROD_W'(sum) * PROD_W'(wsf_recip(weight));
        q_wide   = prod[PROD_W-1:RECIP_SHIFT];
        quotient = (q_wide > QW'(8'hFF)) ? 8'hFF : q_wide[PIX_W-1:0];
    end

endmodule

/* rtl/core/weighted_3x3_smoothing_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_3x3_smoothing_filter
// 3x3 weighted smoothing of an 8-bit grey raster stream with line memories.
// ----------------------------------------------------------------------------
// Pixels (tuser = 0) enter in raster order; inner pixels come out as the
// 1 2 1 / 2 w 2 / 1 2 1 weighted sum divided by w + 12 (truncated), border
// rows and columns pass through. Output lags by one row plus one pixel, so
// after the frame send image_width + 1 drain transactions (tuser = 1) to
// flush the last row. A transaction that leads to a result goes through
// memory read, write-back and window shift, kernel sum and reciprocal
// multiply, which holds while the previous result waits for m_tready; a pixel
// of the first row, or the first pixel of the second row, stops after the
// shift; an ignored one is only accepted. Pixels read-modify-write and drain
// items read the line memories, one item at a time. Configuration must be
// written only while no transaction is in flight (not enforced by the block).
module weighted_3x3_smoothing_filter #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,    // [7:0] pixel_in
    input  logic [0:0]           s_tuser,    // [0] mode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,    // [7:0] pixel_out
    output logic                 m_tlast,    // frame_end
    output logic [1:0]           m_tuser,    // [0] line_end, [1] last_of_run
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [11:0]          cfg_data
);
    import wsf_pkg::*;

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int CNT_W  = $clog2(MAX_WIDTH + 1);
    localparam int POS_W  = (CNT_W > DIM_W) ? CNT_W : DIM_W;

    // configuration
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [WGT_W-1:0] weight_reg;

    // control
    wsf_state_t        state_reg, state_next;
    logic [DIM_W-1:0]  row_cnt_reg, row_cnt_next;
    logic [ADDR_W-1:0] col_cnt_reg, col_cnt_next;
    logic [CNT_W-1:0]  drain_cnt_reg, drain_cnt_next;
    wsf_flags_t        flags_reg, flags_next;
    logic              kind_reg, kind_next;        // MODE_PIXEL or MODE_DRAIN
    logic              drain_hit_reg, drain_hit_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [PIX_W-1:0]  pix_reg, pix_next;

    // output stage
    logic              out_valid_reg;
    logic [PIX_W-1:0]  out_pix_reg;
    logic              out_line_reg;
    logic              out_frame_reg;
    logic              out_load;

    // datapath links
    logic              accept;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [PIX_W-1:0]  upper_q;
    logic [PIX_W-1:0]  middle_q;
    logic              wr_en;
    wsf_col_t          col_new;
    logic              shift_en;
    logic              sum_en;
    logic [SUM_W-1:0]  sum;
    logic [PIX_W-1:0]  center;
    logic [PIX_W-1:0]  quotient;

    // effective geometry and position of the incoming item
    logic [POS_W-1:0]  w_eff;
    logic [POS_W-1:0]  h_eff;
    logic              draining;
    logic              is_pixel;
    logic              is_drain;
    logic [POS_W-1:0]  pos_r;
    logic [POS_W-1:0]  pos_c;
    logic [POS_W-1:0]  orow;
    logic [POS_W-1:0]  ocol;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            weight_reg <= WEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:   width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT:  height_reg <= cfg_data;
                REG_CENTER_WEIGHT: weight_reg <= cfg_data[WGT_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg < MIN_DIM)
            w_eff = POS_W'(MIN_DIM);
        else if (POS_W'(width_reg) > POS_W'(MAX_WIDTH))
            w_eff = POS_W'(MAX_WIDTH);
        else
            w_eff = POS_W'(width_reg);
        h_eff    = (height_reg < MIN_DIM) ? POS_W'(MIN_DIM) : POS_W'(height_reg);
        draining = POS_W'(row_cnt_reg) >= h_eff;
        is_pixel = (s_tuser[0] == MODE_PIXEL) && !draining;
        is_drain = (s_tuser[0] == MODE_DRAIN) && draining;

        pos_r = is_pixel ? POS_W'(row_cnt_reg) : h_eff;
        pos_c = is_pixel ? POS_W'(col_cnt_reg) : POS_W'(drain_cnt_reg);
        if (pos_c != '0)
        begin
            orow = pos_r - POS_W'(1);
            ocol = pos_c - POS_W'(1);
        end
        else
        begin
            orow = pos_r - POS_W'(2);
            ocol = w_eff - POS_W'(1);
        end
        flags_next.emit      = (pos_c != '0) ? (pos_r != '0) : (pos_r >= POS_W'(2));
        flags_next.line_end  = ocol >= w_eff - POS_W'(1);
        flags_next.frame_end = flags_next.line_end && (orow >= h_eff - POS_W'(1));
        flags_next.border    = (orow == '0) || (orow >= h_eff - POS_W'(1))
                            || (ocol == '0) || flags_next.line_end;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign rd_en    = accept && (is_pixel || is_drain);
    assign rd_addr  = is_pixel ? col_cnt_reg : drain_cnt_reg[ADDR_W-1:0];
    assign out_load = (state_reg == ST_SCALE) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next     = state_reg;
        row_cnt_next   = row_cnt_reg;
        col_cnt_next   = col_cnt_reg;
        drain_cnt_next = drain_cnt_reg;
        kind_next      = kind_reg;
        drain_hit_next = drain_hit_reg;
        addr_next      = addr_reg;
        pix_next       = pix_reg;
        wr_en          = 1'b0;
        shift_en       = 1'b0;
        sum_en         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (is_pixel || is_drain))
                begin
                    state_next     = ST_FETCH;
                    kind_next      = is_pixel ? MODE_PIXEL : MODE_DRAIN;
                    drain_hit_next = POS_W'(drain_cnt_reg) < w_eff;
                    addr_next      = col_cnt_reg;
                    pix_next       = s_tdata;
                    if (is_pixel)
                    begin
                        if (POS_W'(col_cnt_reg) + POS_W'(1) >= w_eff)
                        begin
                            col_cnt_next   = '0;
                            row_cnt_next   = row_cnt_reg + DIM_W'(1);
                            drain_cnt_next = '0;
                        end
                        else
                        begin
                            col_cnt_next = col_cnt_reg + ADDR_W'(1);
                        end
                    end
                    else if (POS_W'(drain_cnt_reg) >= w_eff)
                    begin
                        row_cnt_next   = '0;
                        col_cnt_next   = '0;
                        drain_cnt_next = '0;
                    end
                    else
                    begin
                        drain_cnt_next = drain_cnt_reg + CNT_W'(1);
                    end
                end
            end
            ST_FETCH:
            begin
                // line memory data is valid here: write back and shift
                wr_en      = (kind_reg == MODE_PIXEL);
                shift_en   = 1'b1;
                state_next = flags_reg.emit ? ST_SUM : ST_IDLE;
            end
            ST_SUM:
            begin
                sum_en     = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (kind_reg == MODE_PIXEL)
        begin
            col_new[0] = upper_q;
            col_new[1] = middle_q;
            col_new[2] = pix_reg;
        end
        else
        begin
            col_new[0] = '0;
            col_new[1] = drain_hit_reg ? middle_q : '0;
            col_new[2] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_cnt_reg   <= '0;
            col_cnt_reg   <= '0;
            drain_cnt_reg <= '0;
            flags_reg     <= '0;
            kind_reg      <= MODE_PIXEL;
            drain_hit_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_cnt_reg   <= row_cnt_next;
            col_cnt_reg   <= col_cnt_next;
            drain_cnt_reg <= drain_cnt_next;
            kind_reg      <= kind_next;
            drain_hit_reg <= drain_hit_next;
            if (accept)
                flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        pix_reg  <= pix_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_pix_reg   <= flags_reg.border ? center : quotient;
            out_line_reg  <= flags_reg.line_end;
            out_frame_reg <= flags_reg.frame_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pix_reg;
    assign m_tlast  = out_frame_reg;
    assign m_tuser  = {1'b1, out_line_reg};

    wsf_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .clk       (clk),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .upper_q   (upper_q),
        .middle_q  (middle_q),
        .wr_en     (wr_en),
        .wr_addr   (addr_reg),
        .wr_upper  (middle_q),
        .wr_middle (pix_reg)
    );

    wsf_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .col_new  (col_new),
        .sum_en   (sum_en),
        .weight   (weight_reg),
        .sum      (sum),
        .center   (center)
    );

    wsf_scale u_scale (
        .sum      (sum),
        .weight   (weight_reg),
        .quotient (quotient)
    );

endmodule

/* rtl/core/wsf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsf_checker
// Port-level checks for the smoothing filter, bound to the top level.
// ----------------------------------------------------------------------------
module wsf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [1:0] m_tuser
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tlast) && $stable(m_tuser))
        else $error("stalled result changed");

    // end of frame is always also end of line
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("frame end without line end");

    // last_of_run is high on every result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser[1])
        else $error("last_of_run low");

    // a new result only comes out of the scale step, when input is held off
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without processing");

endmodule

bind weighted_3x3_smoothing_filter wsf_checker u_wsf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
